// File: hw/rtl/sms_pkg.sv
// Package for the sparse matrix sign and dominance scan.
// Holds the payload types, the queue entry type, code constants and counter helpers.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sms_pkg;

    localparam int unsigned MAX_DIM     = 65536;
    localparam int unsigned DIM_W       = 17;
    localparam int unsigned IDX_W       = 16;
    localparam int unsigned VAL_W       = 32;
    localparam int unsigned SUM_W       = 48;
    localparam int unsigned CNT17_W     = 17;
    localparam int unsigned CNT32_W     = 32;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 17;

    localparam logic [DIM_W-1:0] MAX_DIM_N = DIM_W'(MAX_DIM);

    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'd1;

    localparam logic       KIND_ENTRY  = 1'b0;
    localparam logic       KIND_FINISH = 1'b1;

    localparam logic [1:0] MODE_AUTO      = 2'd0;
    localparam logic [1:0] MODE_FORCE_LAP = 2'd1;
    localparam logic [1:0] MODE_FORCE_ADJ = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_SYM   = 2'd1;
    localparam logic [1:0] STATUS_AMBIGUOUS = 2'd2;

    localparam logic       DECIDED_LAPLACIAN = 1'b0;
    localparam logic       DECIDED_ADJACENCY = 1'b1;

    localparam logic [1:0] WARN_NONE        = 2'd0;
    localparam logic [1:0] WARN_NO_POS_DIAG = 2'd1;
    localparam logic [1:0] WARN_NEG_WEIGHTS = 2'd2;

    typedef struct packed {
        logic                    kind;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        column_index;
        logic signed [VAL_W-1:0] entry_value;
        logic                    column_last;
    } in_item_t;

    typedef struct packed {
        logic [1:0]              status;
        logic                    decided_kind;
        logic [1:0]              warning;
        logic [CNT17_W-1:0]      positive_diagonals;
        logic [CNT32_W-1:0]      positive_offdiagonals;
        logic [CNT32_W-1:0]      negative_offdiagonals;
        logic [CNT17_W-1:0]      deficient_columns;
        logic [CNT17_W-1:0]      excess_columns;
        logic signed [SUM_W-1:0] worst_sum;
        logic [IDX_W-1:0]        worst_column;
    } out_item_t;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic                    finish;
        logic                    diag_positive;
        logic                    offdiag;
        logic                    off_positive;
        logic                    off_negative;
        logic                    upper;
        logic                    column_last;
        logic [IDX_W-1:0]        column_index;
        logic signed [VAL_W-1:0] entry_value;
    } class_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [CNT17_W-1:0] inc17(input logic [CNT17_W-1:0] c);
        inc17 = (c == {CNT17_W{1'b1}}) ? c : c + CNT17_W'(1);
    endfunction

    function automatic logic [CNT32_W-1:0] inc32(input logic [CNT32_W-1:0] c);
        inc32 = (c == {CNT32_W{1'b1}}) ? c : c + CNT32_W'(1);
    endfunction

endpackage

// File: hw/rtl/sms_front.sv
// Front stage of the scan: accepts input items and classifies each entry.
// Holds one classified item until the queue takes it. Depends on sms_pkg.
`timescale 1ns / 1ps

module sms_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  sms_pkg::in_item_t     item,
    input  sms_pkg::queue_status_t q_status,
    output logic                  push,
    output sms_pkg::class_item_t  push_item
);
    import sms_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    class_item_t item_reg;
    class_item_t item_next;
    logic        accept;
    logic        is_diag;

    assign push       = valid_reg && !q_status.full;
    assign item_ready = !valid_reg || !q_status.full;
    assign accept     = item_valid && item_ready;
    assign push_item  = item_reg;
    assign is_diag    = (item.row_index == item.column_index);

    always_comb
    begin
        item_next.finish        = (item.kind == KIND_FINISH);
        item_next.diag_positive = is_diag && (item.entry_value > 0);
        item_next.offdiag       = !is_diag;
        item_next.off_positive  = !is_diag && (item.entry_value > 0);
        item_next.off_negative  = !is_diag && (item.entry_value < 0);
        item_next.upper         = (item.row_index < item.column_index);
        item_next.column_last   = item.column_last;
        item_next.column_index  = item.column_index;
        item_next.entry_value   = item.entry_value;

        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// File: hw/rtl/sms_queue.sv
// Short queue between the front and back stages of the scan.
// A small register array with read and write pointers. Depends on sms_pkg.
`timescale 1ns / 1ps

module sms_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  sms_pkg::class_item_t   push_item,
    input  logic                   pop,
    output sms_pkg::class_item_t   pop_item,
    output sms_pkg::queue_status_t q_status
);
    import sms_pkg::*;

    class_item_t             mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg;
    logic [QUEUE_AW-1:0]     rd_ptr_reg;
    logic [QUEUE_AW:0]       count_reg;
    logic [QUEUE_AW:0]       count_next;
    logic                    do_push;
    logic                    do_pop;

    assign q_status.full  = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign pop_item       = mem[rd_ptr_reg];

    always_comb
    begin
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + (QUEUE_AW + 1)'(1);
            2'b01:   count_next = count_reg - (QUEUE_AW + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/sms_back.sv
// Back stage of the scan: keeps the column sum and all counts, and on a finish
// item classifies the matrix into the result register and clears. Depends on sms_pkg.
`timescale 1ns / 1ps

module sms_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sms_pkg::queue_status_t       q_status,
    input  sms_pkg::class_item_t         pop_item,
    output logic                         pop,
    input  logic [sms_pkg::DIM_W-1:0]    dim_n,
    input  logic [1:0]                   mode,
    output logic                         result_valid,
    input  logic                         result_ready,
    output sms_pkg::out_item_t           result
);
    import sms_pkg::*;

    logic signed [SUM_W-1:0] column_sum_reg;
    logic signed [SUM_W-1:0] column_sum_next;
    logic [CNT17_W-1:0]      pos_diag_reg;
    logic [CNT17_W-1:0]      pos_diag_next;
    logic [CNT32_W-1:0]      off_total_reg;
    logic [CNT32_W-1:0]      off_total_next;
    logic [CNT32_W-1:0]      off_pos_reg;
    logic [CNT32_W-1:0]      off_pos_next;
    logic [CNT32_W-1:0]      off_neg_reg;
    logic [CNT32_W-1:0]      off_neg_next;
    logic [CNT32_W-1:0]      upper_reg;
    logic [CNT32_W-1:0]      upper_next;
    logic [CNT32_W-1:0]      lower_reg;
    logic [CNT32_W-1:0]      lower_next;
    logic [CNT17_W-1:0]      deficient_reg;
    logic [CNT17_W-1:0]      deficient_next;
    logic [CNT17_W-1:0]      excess_reg;
    logic [CNT17_W-1:0]      excess_next;
    logic signed [SUM_W-1:0] worst_reg;
    logic signed [SUM_W-1:0] worst_next;
    logic [IDX_W-1:0]        worst_idx_reg;
    logic [IDX_W-1:0]        worst_idx_next;
    logic                    result_valid_reg;
    logic                    result_valid_next;
    out_item_t               result_reg;
    out_item_t               result_next;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W-1:0] sum_sat;
    logic                    out_free;
    logic                    load_result;

    assign out_free     = !result_valid_reg || result_ready;
    assign pop          = !q_status.empty && (!pop_item.finish || out_free);
    assign load_result  = pop && pop_item.finish;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        sum_wide = {column_sum_reg[SUM_W-1], column_sum_reg}
                   + (SUM_W + 1)'(pop_item.entry_value);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                      : {1'b0, {(SUM_W - 1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    always_comb
    begin
        column_sum_next = column_sum_reg;
        pos_diag_next   = pos_diag_reg;
        off_total_next  = off_total_reg;
        off_pos_next    = off_pos_reg;
        off_neg_next    = off_neg_reg;
        upper_next      = upper_reg;
        lower_next      = lower_reg;
        deficient_next  = deficient_reg;
        excess_next     = excess_reg;
        worst_next      = worst_reg;
        worst_idx_next  = worst_idx_reg;

        result_next.status                = STATUS_OK;
        result_next.decided_kind          = DECIDED_LAPLACIAN;
        result_next.warning               = WARN_NONE;
        result_next.positive_diagonals    = pos_diag_reg;
        result_next.positive_offdiagonals = off_pos_reg;
        result_next.negative_offdiagonals = off_neg_reg;
        result_next.deficient_columns     = deficient_reg;
        result_next.excess_columns        = excess_reg;
        result_next.worst_sum             = worst_reg;
        result_next.worst_column          = worst_idx_reg;

        priority if (off_total_reg != '0 && (upper_reg == '0 || lower_reg == '0))
        begin
            result_next.status = STATUS_NOT_SYM;
        end
        else if (mode == MODE_FORCE_LAP)
        begin
            if (pos_diag_reg == '0 && dim_n != '0)
            begin
                result_next.warning = WARN_NO_POS_DIAG;
            end
            else if (off_pos_reg != '0)
            begin
                result_next.warning = WARN_NEG_WEIGHTS;
            end
        end
        else if (mode == MODE_FORCE_ADJ)
        begin
            result_next.decided_kind = DECIDED_ADJACENCY;
        end
        else if (off_total_reg == '0 || off_pos_reg == '0)
        begin
            result_next.decided_kind = DECIDED_LAPLACIAN;
        end
        else if (off_neg_reg == '0)
        begin
            result_next.decided_kind = DECIDED_ADJACENCY;
        end
        else if (pos_diag_reg == dim_n)
        begin
            result_next.decided_kind = DECIDED_LAPLACIAN;
        end
        else
        begin
            result_next.status = STATUS_AMBIGUOUS;
        end

        if (pop && pop_item.finish)
        begin
            column_sum_next = '0;
            pos_diag_next   = '0;
            off_total_next  = '0;
            off_pos_next    = '0;
            off_neg_next    = '0;
            upper_next      = '0;
            lower_next      = '0;
            deficient_next  = '0;
            excess_next     = '0;
            worst_next      = '0;
            worst_idx_next  = '0;
        end
        else if (pop)
        begin
            if (pop_item.diag_positive)
            begin
                pos_diag_next = inc17(pos_diag_reg);
            end
            if (pop_item.offdiag)
            begin
                off_total_next = inc32(off_total_reg);
                if (pop_item.upper)
                begin
                    upper_next = inc32(upper_reg);
                end
                else
                begin
                    lower_next = inc32(lower_reg);
                end
            end
            if (pop_item.off_positive)
            begin
                off_pos_next = inc32(off_pos_reg);
            end
            if (pop_item.off_negative)
            begin
                off_neg_next = inc32(off_neg_reg);
            end
            if (pop_item.column_last)
            begin
                column_sum_next = '0;
                if (sum_sat < 0)
                begin
                    deficient_next = inc17(deficient_reg);
                    if (sum_sat < worst_reg)
                    begin
                        worst_next     = sum_sat;
                        worst_idx_next = pop_item.column_index;
                    end
                end
                else if (sum_sat > 0)
                begin
                    excess_next = inc17(excess_reg);
                end
            end
            else
            begin
                column_sum_next = sum_sat;
            end
        end

        if (load_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_sum_reg   <= '0;
            pos_diag_reg     <= '0;
            off_total_reg    <= '0;
            off_pos_reg      <= '0;
            off_neg_reg      <= '0;
            upper_reg        <= '0;
            lower_reg        <= '0;
            deficient_reg    <= '0;
            excess_reg       <= '0;
            worst_reg        <= '0;
            worst_idx_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            column_sum_reg   <= column_sum_next;
            pos_diag_reg     <= pos_diag_next;
            off_total_reg    <= off_total_next;
            off_pos_reg      <= off_pos_next;
            off_neg_reg      <= off_neg_next;
            upper_reg        <= upper_next;
            lower_reg        <= lower_next;
            deficient_reg    <= deficient_next;
            excess_reg       <= excess_next;
            worst_reg        <= worst_next;
            worst_idx_reg    <= worst_idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// File: hw/rtl/sparse_matrix_sign_dominance_scan.sv
// Top level of the sparse matrix sign and dominance scan.
// Holds the configuration registers and joins front, queue and back stages.
// Depends on sms_pkg, sms_front, sms_queue and sms_back.
//
// Matrix entries enter on the item channel in column-major order, the last
// entry of each column marked, one transfer per cycle with no gaps needed.
// Entries produce no result; a finish item produces one transfer on the
// result channel carrying the classification and the counts, and then
// clears every count and the running column sum.
// A finish item's result passes through the front register and the queue,
// and then sits in the back stage's result register until it transfers.
// Sustained throughput is one item per cycle, set by the single add and
// compare on the column sum, while no finish item waits on a stalled receiver.
// The configuration port writes dimension and requested mode; write them
// only while no item is in flight.
// Reset clears the configuration, all counts and the pipeline; no clearing
// pass is needed.
// When the receiver stalls, the result register holds its result, the back
// stage keeps draining entries up to the next finish item, and the
// four-entry queue and the front register absorb items before item_ready drops.
`timescale 1ns / 1ps

module sparse_matrix_sign_dominance_scan (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sms_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  sms_pkg::in_item_t               item,
    output logic                            result_valid,
    input  logic                            result_ready,
    output sms_pkg::out_item_t              result
);
    import sms_pkg::*;

    logic [DIM_W-1:0] dimension_reg;
    logic [1:0]       mode_reg;
    logic [DIM_W-1:0] dim_n;
    queue_status_t    q_status;
    logic             push;
    logic             pop;
    class_item_t      push_item;
    class_item_t      pop_item;

    assign dim_n = (dimension_reg > MAX_DIM_N) ? MAX_DIM_N : dimension_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg <= '0;
            mode_reg      <= MODE_AUTO;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIMENSION: dimension_reg <= cfg_data[DIM_W-1:0];
                CFG_MODE:      mode_reg      <= cfg_data[1:0];
                default:       mode_reg      <= mode_reg;
            endcase
        end
    end

    sms_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_status   (q_status),
        .push       (push),
        .push_item  (push_item)
    );

    sms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_status  (q_status)
    );

    sms_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .pop_item     (pop_item),
        .pop          (pop),
        .dim_n        (dim_n),
        .mode         (mode_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
